// ----- rtl/sequence_gap_checker_macros.svh -----
// ----------------------------------------------------------------------------
// sequence gap checker assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_GAP_CHECKER_MACROS_SVH
`define SEQUENCE_GAP_CHECKER_MACROS_SVH

// same-cycle implication, off during reset
`define SGC_ASSERT_NOW(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("sequence gap checker assertion failed");

// next-cycle implication, off during reset
`define SGC_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("sequence gap checker assertion failed");

// condition that must hold in the cycle after reset is seen
`define SGC_ASSERT_RESET(lbl, clk, rstn, post) \
    lbl: assert property (@(posedge clk) (!rstn) |=> (post)) \
        else $error("sequence gap checker reset assertion failed");

`endif

// ----- rtl/sgc_pkg.sv -----
// ----------------------------------------------------------------------------
// sgc_pkg
// types and constants of the sequence gap checker
// ----------------------------------------------------------------------------
package sgc_pkg;

    localparam int IDENT_W   = 29;
    localparam int LENGTH_W  = 4;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 104;
    localparam int M_DATA_W  = 160;

    localparam logic [CFG_IDX_W-1:0] CFG_TEST_FRAME_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD  = 2'd2;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [IDENT_W-1:0]  TEST_FRAME_ID_RST = 29'h7E0;
    localparam logic [WORD_W-1:0]   SILENCE_LIMIT_RST = 32'd500000;
    localparam logic [WORD_W-1:0]   PATTERN_WORD_RST  = 32'hAA55AA55;
    localparam logic [LENGTH_W-1:0] FULL_LENGTH       = 4'd8;

    typedef struct packed {
        logic [WORD_W-1:0] elapsed_ticks;
        logic [WORD_W-1:0] corrupt_total;
        logic [WORD_W-1:0] lost_total;
        logic [WORD_W-1:0] expected_total;
        logic [WORD_W-1:0] frame_total;
    } result_t;

endpackage

// ----- rtl/sequence_gap_checker.sv -----
// ----------------------------------------------------------------------------
// sequence_gap_checker
// follows test frame sequence numbers and reports a summary after silence
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one beat is a received frame (s_tuser low) or a time tick
//   (s_tuser high). frames with another identifier are dropped. m_ channel
//   carries one summary beat on the tick whose silence since the last test
//   frame exceeds silence_limit. cfg channel writes test_frame_id,
//   silence_limit and pattern_word by index; cfg_ready is always high and
//   writes are meant for an idle block.
//   path: input register, then state update, then output register (m_tvalid).
//   throughput: one beat per cycle while no tick waits for the output
//   register, set by the single state update stage.
//   stall: a summary waits in the output register; frames keep flowing,
//   a tick waits in the input register until the output register frees,
//   and s_tready drops only while that tick waits.
//   reset: all counters clear, no test is running, registers take their
//   defaults; s_tready is high right after reset.
// ----------------------------------------------------------------------------
module sequence_gap_checker
    import sgc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // frame_ident, frame_length, payload_low, payload_high, zero pad
    input  logic [S_DATA_W-1:0]  s_tdata,
    // kind
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // frame_total, expected_total, lost_total, corrupt_total, elapsed_ticks
    output logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    logic [IDENT_W-1:0] test_frame_id_reg;
    logic [WORD_W-1:0]  silence_limit_reg;
    logic [WORD_W-1:0]  pattern_word_reg;

    logic                in_valid_reg;
    logic                in_kind_reg;
    logic [IDENT_W-1:0]  in_ident_reg;
    logic [LENGTH_W-1:0] in_length_reg;
    logic [WORD_W-1:0]   in_seq_reg;
    logic [WORD_W-1:0]   in_pat_reg;

    logic              running_reg, running_next;
    logic [WORD_W-1:0] now_reg, now_next;
    logic [WORD_W-1:0] start_reg, start_next;
    logic [WORD_W-1:0] last_tick_reg, last_tick_next;
    logic [WORD_W-1:0] frames_reg, frames_next;
    logic [WORD_W-1:0] last_seq_reg, last_seq_next;
    logic [WORD_W-1:0] lost_reg, lost_next;
    logic [WORD_W-1:0] corrupt_reg, corrupt_next;

    logic    out_valid_reg;
    result_t out_reg, out_next;

    logic              out_free;
    logic              proc;
    logic              emit;
    logic [WORD_W-1:0] now_inc;
    logic [WORD_W-1:0] silence;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign proc      = in_valid_reg && (out_free || in_kind_reg == KIND_FRAME);
    assign s_tready  = !in_valid_reg || proc;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    assign now_inc = now_reg + 32'd1;
    assign silence = now_inc - last_tick_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            test_frame_id_reg <= TEST_FRAME_ID_RST;
            silence_limit_reg <= SILENCE_LIMIT_RST;
            pattern_word_reg  <= PATTERN_WORD_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_TEST_FRAME_ID: test_frame_id_reg <= cfg_data[IDENT_W-1:0];
                CFG_SILENCE_LIMIT: silence_limit_reg <= cfg_data;
                CFG_PATTERN_WORD:  pattern_word_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg   <= s_tuser;
            in_ident_reg  <= s_tdata[28:0];
            in_length_reg <= s_tdata[32:29];
            in_seq_reg    <= s_tdata[64:33];
            in_pat_reg    <= s_tdata[96:65];
        end
    end

    always_comb begin
        running_next   = running_reg;
        now_next       = now_reg;
        start_next     = start_reg;
        last_tick_next = last_tick_reg;
        frames_next    = frames_reg;
        last_seq_next  = last_seq_reg;
        lost_next      = lost_reg;
        corrupt_next   = corrupt_reg;
        emit           = 1'b0;

        out_next.frame_total    = frames_reg;
        out_next.expected_total = frames_reg + lost_reg;
        out_next.lost_total     = lost_reg;
        out_next.corrupt_total  = corrupt_reg;
        out_next.elapsed_ticks  = last_tick_reg - start_reg;

        if (in_kind_reg == KIND_TICK) begin
            now_next = now_inc;
            if (running_reg && silence > silence_limit_reg) begin
                running_next = 1'b0;
                emit         = 1'b1;
            end
        end else if (in_ident_reg == test_frame_id_reg) begin
            if (in_length_reg < FULL_LENGTH) begin
                corrupt_next = corrupt_reg + 32'd1;
            end else if (!running_reg) begin
                running_next   = 1'b1;
                start_next     = now_reg;
                last_tick_next = now_reg;
                frames_next    = 32'd1;
                last_seq_next  = in_seq_reg;
                lost_next      = '0;
                corrupt_next   = '0;
            end else begin
                if (in_pat_reg != pattern_word_reg) begin
                    corrupt_next = corrupt_reg + 32'd1;
                end
                frames_next    = frames_reg + 32'd1;
                lost_next      = lost_reg + (in_seq_reg - last_seq_reg - 32'd1);
                last_seq_next  = in_seq_reg;
                last_tick_next = now_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg   <= 1'b0;
            now_reg       <= '0;
            start_reg     <= '0;
            last_tick_reg <= '0;
            frames_reg    <= '0;
            last_seq_reg  <= '0;
            lost_reg      <= '0;
            corrupt_reg   <= '0;
        end else if (proc) begin
            running_reg   <= running_next;
            now_reg       <= now_next;
            start_reg     <= start_next;
            last_tick_reg <= last_tick_next;
            frames_reg    <= frames_next;
            last_seq_reg  <= last_seq_next;
            lost_reg      <= lost_next;
            corrupt_reg   <= corrupt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && emit) begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- rtl/sgc_checker.sv -----
// ----------------------------------------------------------------------------
// sgc_checker
// port-level checks of the sequence gap checker
// ----------------------------------------------------------------------------
`include "sequence_gap_checker_macros.svh"

module sgc_checker
    import sgc_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    `SGC_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `SGC_ASSERT_NEXT(a_m_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    `SGC_ASSERT_NOW(a_expected_sum, aclk, aresetn, m_tvalid,
        m_tdata[63:32] == m_tdata[31:0] + m_tdata[95:64])
    `SGC_ASSERT_RESET(a_reset_idle, aclk, aresetn, !m_tvalid && s_tready)

endmodule

bind sequence_gap_checker sgc_checker u_sgc_checker (.*);
